>>> hdl/bmpepd_pkg.sv
// ----------------------------------------------------------------------------
// bmpepd_pkg
// Shared types and constants of the 4 bpp BMP to e-paper frame buffer decoder.
// ----------------------------------------------------------------------------
package bmpepd_pkg;

    // Result address width of the frame buffer
    localparam int ADDR_W = 19;

    // Palette layout
    localparam int PAL_ENTRIES = 16;
    localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
    localparam int CLR_W       = 3;

    // Byte positions of the header fields
    localparam logic [31:0] OFFSET_POS = 32'd10;
    localparam logic [31:0] WIDTH_POS  = 32'd18;
    localparam logic [31:0] HEIGHT_POS = 32'd22;
    localparam logic [31:0] BPP_POS    = 32'd28;
    localparam logic [31:0] CHECK_POS  = 32'd29;
    localparam logic [31:0] PAL_START  = 32'd54;
    localparam logic [31:0] PAL_END    = PAL_START + 32'(4 * PAL_ENTRIES);

    localparam logic [15:0] BPP_REQUIRED = 16'd4;

    // Status codes
    localparam logic [2:0] ST_BUSY       = 3'd0;
    localparam logic [2:0] ST_DONE       = 3'd1;
    localparam logic [2:0] ST_BAD_BPP    = 3'd2;
    localparam logic [2:0] ST_BAD_WIDTH  = 3'd3;
    localparam logic [2:0] ST_BAD_HEIGHT = 3'd4;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd5;
    localparam logic [2:0] ERR_NONE      = 3'd0;

    // Configuration register indexes
    localparam logic CFG_EXP_WIDTH  = 1'b0;
    localparam logic CFG_EXP_HEIGHT = 1'b1;

    // Per-word control from the header parser
    typedef struct packed {
        logic [2:0]           err;       // error code after this word's check
        logic                 window;    // word lies in the pixel data area
        logic                 pal_valid; // word lies in the palette area
        logic [1:0]           pal_lane;  // byte lane within the palette dword
        logic [PAL_IDX_W-1:0] pal_index; // palette entry
    } hdr_ctl_t;

endpackage

>>> hdl/bmpepd_ram.sv
// ----------------------------------------------------------------------------
// bmpepd_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bmpepd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

>>> hdl/bmpepd_hdr.sv
// ----------------------------------------------------------------------------
// bmpepd_hdr
// Byte position counter, header field capture and header check.
// ----------------------------------------------------------------------------
module bmpepd_hdr import bmpepd_pkg::*; #(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  MAX_HEIGHT = 1024,
    localparam int BPL_W      = $clog2(MAX_WIDTH / 2 + 1),
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  logic [7:0]       file_byte,
    input  logic             first_byte,
    input  logic [10:0]      exp_width,
    input  logic [10:0]      exp_height,
    output hdr_ctl_t         ctl,
    output logic [BPL_W-1:0] bpl,
    output logic [ROW_W-1:0] height
);

    logic [31:0] pos_reg;
    logic [31:0] offset_reg;
    logic [31:0] width_reg;
    logic [31:0] height_reg;
    logic [15:0] bpp_reg;
    logic [2:0]  err_reg;

    logic [31:0] pos_eff;
    logic [31:0] pos_next;
    logic [31:0] offset_next;
    logic [31:0] width_next;
    logic [31:0] height_next;
    logic [15:0] bpp_next;
    logic [2:0]  err_eff;
    logic [2:0]  err_next;
    logic [5:0]  pal_rel;

    // Drop byte b into the little-endian dword at start, if pos falls in it
    function automatic logic [31:0] put_dword(input logic [31:0] cur,
                                              input logic [31:0] pos,
                                              input logic [31:0] start,
                                              input logic [7:0]  b);
        logic [31:0] res;
        logic [31:0] rel;
        res = cur;
        rel = pos - start;
        if (pos >= start && rel < 32'd4) begin
            res[{rel[1:0], 3'b000} +: 8] = b;
        end
        return res;
    endfunction

    always_comb begin
        // A start mark restarts the file before this word is parsed
        pos_eff     = first_byte ? '0 : pos_reg;
        err_eff     = first_byte ? ERR_NONE : err_reg;
        offset_next = put_dword(first_byte ? '0 : offset_reg, pos_eff, OFFSET_POS, file_byte);
        width_next  = put_dword(first_byte ? '0 : width_reg, pos_eff, WIDTH_POS, file_byte);
        height_next = put_dword(first_byte ? '0 : height_reg, pos_eff, HEIGHT_POS, file_byte);

        bpp_next = first_byte ? '0 : bpp_reg;
        if (pos_eff == BPP_POS) begin
            bpp_next[7:0] = file_byte;
        end
        if (pos_eff == BPP_POS + 32'd1) begin
            bpp_next[15:8] = file_byte;
        end

        err_next = err_eff;
        if (pos_eff == CHECK_POS && err_eff == ERR_NONE) begin
            if (bpp_next != BPP_REQUIRED) begin
                err_next = ST_BAD_BPP;
            end else if (width_next != 32'(exp_width) || width_next > 32'(MAX_WIDTH)) begin
                err_next = ST_BAD_WIDTH;
            end else if (height_next != 32'(exp_height)
                         || height_next > 32'(MAX_HEIGHT)) begin
                err_next = ST_BAD_HEIGHT;
            end else if (offset_next < PAL_END) begin
                err_next = ST_BAD_OFFSET;
            end
        end

        // Saturate at the top of the range
        pos_next = (pos_eff == '1) ? pos_eff : pos_eff + 32'd1;

        pal_rel = 6'(pos_eff[5:0] - PAL_START[5:0]);

        ctl.err       = err_next;
        ctl.window    = (pos_eff > CHECK_POS) && (pos_eff >= offset_next);
        ctl.pal_valid = (pos_eff >= PAL_START) && (pos_eff < PAL_END);
        ctl.pal_lane  = pal_rel[1:0];
        ctl.pal_index = pal_rel[5:2];
    end

    // Only the low bits matter once the header check has passed
    assign bpl    = width_reg[BPL_W:1];
    assign height = height_reg[ROW_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            bpp_reg    <= '0;
            err_reg    <= ERR_NONE;
        end else if (fire) begin
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            bpp_reg    <= bpp_next;
            err_reg    <= err_next;
        end
    end

endmodule

>>> hdl/bmpepd_pal.sv
// ----------------------------------------------------------------------------
// bmpepd_pal
// Palette dword assembly, colour mapping and the colour table lookup.
// ----------------------------------------------------------------------------
module bmpepd_pal import bmpepd_pkg::*; (
    input  logic             aclk,
    input  logic             fire,
    input  hdr_ctl_t         ctl,
    input  logic [7:0]       cur_byte,
    input  logic             in_accept,
    input  logic [7:0]       in_byte,
    output logic [CLR_W-1:0] lo_code,
    output logic [CLR_W-1:0] hi_code
);

    localparam logic [31:0] DW_RED    = 32'h00ed1c24;
    localparam logic [31:0] DW_BLK    = 32'h00000000;
    localparam logic [31:0] DW_GRN    = 32'h0022b14c;
    localparam logic [31:0] DW_YEL    = 32'h00fff200;
    localparam logic [31:0] DW_BLU    = 32'h003f48cc;
    localparam logic [31:0] DW_SKIN   = 32'h00ffe282;
    localparam logic [31:0] DW_WHT    = 32'h00ffffff;

    localparam logic [CLR_W-1:0] CLR_BLACK       = 3'd0;
    localparam logic [CLR_W-1:0] CLR_WHITE       = 3'd1;
    localparam logic [CLR_W-1:0] CLR_GREEN       = 3'd2;
    localparam logic [CLR_W-1:0] CLR_BLUE        = 3'd3;
    localparam logic [CLR_W-1:0] CLR_RED         = 3'd4;
    localparam logic [CLR_W-1:0] CLR_YELLOW      = 3'd5;
    localparam logic [CLR_W-1:0] CLR_TRANSPARENT = 3'd7;

    logic [23:0]          asm_reg;
    logic                 byp_lo_reg;
    logic                 byp_hi_reg;
    logic [CLR_W-1:0]     byp_data_reg;
    logic                 wr_en;
    logic [PAL_IDX_W-1:0] wr_addr;
    logic [CLR_W-1:0]     wr_data;
    logic [CLR_W-1:0]     rd_lo;
    logic [CLR_W-1:0]     rd_hi;

    function automatic logic [CLR_W-1:0] map_color(input logic [31:0] dword);
        logic [CLR_W-1:0] code;
        unique case (dword)
            DW_RED:  code = CLR_RED;
            DW_BLK:  code = CLR_BLACK;
            DW_GRN:  code = CLR_GREEN;
            DW_YEL:  code = CLR_YELLOW;
            DW_BLU:  code = CLR_BLUE;
            DW_SKIN: code = CLR_TRANSPARENT;
            DW_WHT:  code = CLR_WHITE;
            default: code = CLR_TRANSPARENT;
        endcase
        return code;
    endfunction

    assign wr_en   = fire && ctl.pal_valid && (ctl.pal_lane == 2'd3);
    assign wr_addr = ctl.pal_index;
    assign wr_data = map_color({cur_byte, asm_reg});

    always_ff @(posedge aclk) begin
        if (fire && ctl.pal_valid && ctl.pal_lane != 2'd3) begin
            asm_reg[{ctl.pal_lane, 3'b000} +: 8] <= cur_byte;
        end
        // Forward an entry written in the same cycle as it is read
        if (in_accept) begin
            byp_lo_reg   <= wr_en && (wr_addr == in_byte[3:0]);
            byp_hi_reg   <= wr_en && (wr_addr == in_byte[7:4]);
            byp_data_reg <= wr_data;
        end
    end

    bmpepd_ram #(
        .WIDTH (CLR_W),
        .DEPTH (PAL_ENTRIES)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (in_accept),
        .rd_addr_a (in_byte[3:0]),
        .rd_addr_b (in_byte[7:4]),
        .rd_data_a (rd_lo),
        .rd_data_b (rd_hi)
    );

    assign lo_code = byp_lo_reg ? byp_data_reg : rd_lo;
    assign hi_code = byp_hi_reg ? byp_data_reg : rd_hi;

endmodule

>>> hdl/bmpepd_pix.sv
// ----------------------------------------------------------------------------
// bmpepd_pix
// Row and column counters, mirrored write address, pixel word and status.
// ----------------------------------------------------------------------------
module bmpepd_pix import bmpepd_pkg::*; #(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  MAX_HEIGHT = 1024,
    localparam int BPL_W      = $clog2(MAX_WIDTH / 2 + 1),
    localparam int COL_W      = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1,
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic              first_byte,
    input  hdr_ctl_t          ctl,
    input  logic [BPL_W-1:0]  bpl,
    input  logic [ROW_W-1:0]  height,
    input  logic [CLR_W-1:0]  lo_code,
    input  logic [CLR_W-1:0]  hi_code,
    output logic              write_valid,
    output logic [ADDR_W-1:0] write_address,
    output logic [7:0]        write_data,
    output logic [2:0]        status
);

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] base_reg;

    logic [COL_W-1:0]  col_eff;
    logic [ROW_W-1:0]  row_eff;
    logic [ADDR_W-1:0] base_eff;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [ADDR_W-1:0] base_next;
    logic [BPL_W-1:0]  col_inc;
    logic              row_end;
    logic              emit;
    logic              done;

    always_comb begin
        col_eff  = first_byte ? '0 : col_reg;
        row_eff  = first_byte ? '0 : row_reg;
        base_eff = first_byte ? '0 : base_reg;

        emit    = (ctl.err == ERR_NONE) && ctl.window && (bpl != '0) && (row_eff < height);
        col_inc = BPL_W'(col_eff) + BPL_W'(1);
        row_end = (col_inc >= bpl);

        col_next  = col_eff;
        row_next  = row_eff;
        base_next = base_eff;
        if (emit) begin
            if (row_end) begin
                col_next  = '0;
                row_next  = row_eff + ROW_W'(1);
                base_next = base_eff + ADDR_W'(bpl);
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end

        write_valid   = emit;
        write_address = '0;
        write_data    = '0;
        if (emit) begin
            // Mirror within the row: last column first
            write_address = base_eff + ADDR_W'(bpl) - ADDR_W'(col_eff) - ADDR_W'(1);
            write_data    = {1'b0, lo_code, 1'b0, hi_code};
        end

        done = (bpl == '0) || (row_next >= height);
        if (ctl.err != ERR_NONE) begin
            status = ctl.err;
        end else if (ctl.window) begin
            status = done ? ST_DONE : ST_BUSY;
        end else begin
            status = ST_BUSY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end else if (fire) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

>>> hdl/bmp4_to_epd_palette_remap_mirror_top.sv
// A word accepted on s_ passes the input register, then the result register,
// before its result is offered on m_; throughput is one word per cycle while
// m_ready holds, set by the single pass through parser, table and adder.
// The colour table is a 16-entry RAM with registered read, addressed at input.
// Reset clears the byte position, header fields, error and counters, and loads
// expected width 600 and height 448; the colour table holds garbage until written.
// ----------------------------------------------------------------------------
// bmp4_to_epd_palette_remap_mirror_top
// 4 bpp BMP stream decoder with palette remap and row-mirrored frame writes.
// ----------------------------------------------------------------------------
module bmp4_to_epd_palette_remap_mirror_top import bmpepd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_file_byte,
    input  logic              s_first_byte,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_write_valid,
    output logic [ADDR_W-1:0] m_write_address,
    output logic [7:0]        m_write_data,
    output logic [2:0]        m_status,
    // configuration channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [10:0]       cfg_data
);

    localparam int BPL_W = $clog2(MAX_WIDTH / 2 + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

    logic [10:0]       exp_width_reg;
    logic [10:0]       exp_height_reg;

    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic              s1_first_reg;

    logic              out_valid_reg;
    logic              out_write_valid_reg;
    logic [ADDR_W-1:0] out_address_reg;
    logic [7:0]        out_data_reg;
    logic [2:0]        out_status_reg;

    logic              advance;
    logic              accept;
    hdr_ctl_t          ctl;
    logic [BPL_W-1:0]  bpl;
    logic [ROW_W-1:0]  height;
    logic [CLR_W-1:0]  lo_code;
    logic [CLR_W-1:0]  hi_code;
    logic              pix_valid;
    logic [ADDR_W-1:0] pix_address;
    logic [7:0]        pix_data;
    logic [2:0]        pix_status;

    // Advance the held word whenever the result register is free or drains
    assign advance   = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || advance;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_width_reg  <= 11'd600;
            exp_height_reg <= 11'd448;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_EXP_WIDTH:  exp_width_reg  <= cfg_data;
                CFG_EXP_HEIGHT: exp_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_byte_reg  <= s_file_byte;
            s1_first_reg <= s_first_byte;
        end
        if (advance) begin
            out_write_valid_reg <= pix_valid;
            out_address_reg     <= pix_address;
            out_data_reg        <= pix_data;
            out_status_reg      <= pix_status;
        end
    end

    bmpepd_hdr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_hdr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (advance),
        .file_byte  (s1_byte_reg),
        .first_byte (s1_first_reg),
        .exp_width  (exp_width_reg),
        .exp_height (exp_height_reg),
        .ctl        (ctl),
        .bpl        (bpl),
        .height     (height)
    );

    bmpepd_pal u_pal (
        .aclk      (aclk),
        .fire      (advance),
        .ctl       (ctl),
        .cur_byte  (s1_byte_reg),
        .in_accept (accept),
        .in_byte   (s_file_byte),
        .lo_code   (lo_code),
        .hi_code   (hi_code)
    );

    bmpepd_pix #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pix (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (advance),
        .first_byte    (s1_first_reg),
        .ctl           (ctl),
        .bpl           (bpl),
        .height        (height),
        .lo_code       (lo_code),
        .hi_code       (hi_code),
        .write_valid   (pix_valid),
        .write_address (pix_address),
        .write_data    (pix_data),
        .status        (pix_status)
    );

    assign m_valid         = out_valid_reg;
    assign m_write_valid   = out_write_valid_reg;
    assign m_write_address = out_address_reg;
    assign m_write_data    = out_data_reg;
    assign m_status        = out_status_reg;

    // A pixel write never carries an error status
    a_write_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_valid) |-> (m_status == ST_BUSY || m_status == ST_DONE))
        else $error("pixel write with error status");

    // Colour codes are three bits, so the top bit of each nibble stays clear
    a_data_nibbles: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_valid) |-> (m_write_data[7] == 1'b0 && m_write_data[3] == 1'b0))
        else $error("pixel nibble out of range");

    // A word moved out of the input register shows up on the result side
    a_advance_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced word lost");

endmodule

>>> tb/bmp4_to_epd_palette_remap_mirror_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmp4_to_epd_palette_remap_mirror_top_tb
// Streams 4 bpp BMP files into the decoder under random stalls on both sides
// and checks every result word against a byte-by-byte decoder model. A short
// table of header corner cases comes first, then randomly shaped files.
// ----------------------------------------------------------------------------
module bmp4_to_epd_palette_remap_mirror_top_tb import bmpepd_pkg::*;;

    localparam int DEC_MAX_WIDTH  = 1024;
    localparam int DEC_MAX_HEIGHT = 1024;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_ITEMS    = 1600;

    localparam logic [31:0] FSIZE_POS = 32'd2;

    // Palette dwords as 0x00RRGGBB
    localparam logic [31:0] DW_RED   = 32'h00ed1c24;
    localparam logic [31:0] DW_BLK   = 32'h00000000;
    localparam logic [31:0] DW_GRN   = 32'h0022b14c;
    localparam logic [31:0] DW_YEL   = 32'h00fff200;
    localparam logic [31:0] DW_BLU   = 32'h003f48cc;
    localparam logic [31:0] DW_PEACH = 32'h00ffe282;
    localparam logic [31:0] DW_WHT   = 32'h00ffffff;
    localparam logic [31:0] KNOWN_RGB [7] = '{DW_RED, DW_BLK, DW_GRN, DW_YEL,
                                              DW_BLU, DW_PEACH, DW_WHT};

    // Display colour codes
    localparam logic [2:0] CODE_BLK   = 3'd0;
    localparam logic [2:0] CODE_WHT   = 3'd1;
    localparam logic [2:0] CODE_GRN   = 3'd2;
    localparam logic [2:0] CODE_BLU   = 3'd3;
    localparam logic [2:0] CODE_RED   = 3'd4;
    localparam logic [2:0] CODE_YEL   = 3'd5;
    localparam logic [2:0] CODE_CLEAR = 3'd7;

    // File palette and pixel fill styles
    localparam logic       PAL_KNOWN   = 1'b0;
    localparam logic       PAL_MIXED   = 1'b1;
    localparam logic [1:0] FILL_RANDOM = 2'd0;
    localparam logic [1:0] FILL_ZERO   = 2'd1;
    localparam logic [1:0] FILL_ONES   = 2'd2;
    localparam logic [1:0] FILL_ALT    = 2'd3;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [2:0]        status;
    } fb_write_t;

    typedef struct packed {
        logic [10:0] cw;     // geometry registers for this file
        logic [10:0] ch;
        logic        mark;   // flag the first byte
        logic [15:0] bpp;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] offs;
        logic [15:0] npix;   // bytes after the data offset
        logic [15:0] trunc;  // cut the file after this many bytes, 0 for none
        logic        pal;
        logic [1:0]  fill;
        logic        chk;    // status of the last word is given below
        logic [2:0]  st;
    } bmp_file_t;

    localparam int DIR_ROWS = 18;
    localparam bmp_file_t DIR_PLAN [DIR_ROWS] = '{
        '{11'd600, 11'd448, 1'b0, 16'd4, 32'd600, 32'd448, 32'd118, 16'd8, 16'd0,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BUSY},
        '{11'd600, 11'd448, 1'b1, 16'd8, 32'd600, 32'd448, 32'd118, 16'd4, 16'd30,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BAD_BPP},
        '{11'd600, 11'd448, 1'b1, 16'h0104, 32'd600, 32'd448, 32'd118, 16'd4, 16'd30,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BAD_BPP},
        '{11'd600, 11'd448, 1'b1, 16'd4, 32'd601, 32'd448, 32'd118, 16'd4, 16'd30,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BAD_WIDTH},
        '{11'd600, 11'd448, 1'b1, 16'd4, 32'h01000258, 32'd448, 32'd118, 16'd4, 16'd30,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BAD_WIDTH},
        '{11'd600, 11'd448, 1'b1, 16'd4, 32'd600, 32'd447, 32'd118, 16'd4, 16'd30,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BAD_HEIGHT},
        '{11'd600, 11'd448, 1'b1, 16'd4, 32'd600, 32'h000101c0, 32'd118, 16'd4, 16'd30,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BAD_HEIGHT},
        '{11'd600, 11'd448, 1'b1, 16'd4, 32'd600, 32'd448, 32'd117, 16'd4, 16'd30,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BAD_OFFSET},
        '{11'd600, 11'd448, 1'b1, 16'd4, 32'd600, 32'd448, 32'd0, 16'd4, 16'd30,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BAD_OFFSET},
        '{11'd600, 11'd448, 1'b1, 16'hffff, 32'hffffffff, 32'hffffffff, 32'd0, 16'd4,
          16'd30, PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BAD_BPP},
        '{11'd600, 11'd448, 1'b1, 16'd4, 32'd600, 32'd448, 32'hffffffff, 16'd8, 16'd0,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BUSY},
        '{11'd600, 11'd448, 1'b1, 16'd4, 32'd600, 32'd448, 32'd118, 16'd0, 16'd20,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BUSY},
        '{11'd2, 11'd1, 1'b1, 16'd4, 32'd2, 32'd1, 32'd118, 16'd3, 16'd0,
          PAL_KNOWN, FILL_ZERO, 1'b1, ST_DONE},
        '{11'd3, 11'd2, 1'b1, 16'd4, 32'd3, 32'd2, 32'd118, 16'd2, 16'd0,
          PAL_KNOWN, FILL_ONES, 1'b1, ST_DONE},
        '{11'd6, 11'd3, 1'b1, 16'd4, 32'd6, 32'd3, 32'd125, 16'd9, 16'd0,
          PAL_MIXED, FILL_ALT, 1'b1, ST_DONE},
        '{11'd1024, 11'd1024, 1'b1, 16'd4, 32'd1024, 32'd1024, 32'd118, 16'd16, 16'd0,
          PAL_MIXED, FILL_RANDOM, 1'b1, ST_BUSY},
        '{11'd48, 11'd1, 1'b1, 16'd4, 32'd48, 32'd1, 32'd118, 16'd26, 16'd0,
          PAL_MIXED, FILL_RANDOM, 1'b1, ST_DONE},
        '{11'd2, 11'd1024, 1'b1, 16'd4, 32'd2, 32'd1024, 32'd118, 16'd16, 16'd0,
          PAL_KNOWN, FILL_RANDOM, 1'b1, ST_BUSY}
    };

    logic              aclk;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [7:0]        s_file_byte     = 8'd0;
    logic              s_first_byte    = 1'b0;
    logic              m_valid;
    logic              m_ready         = 1'b1;
    logic              m_write_valid;
    logic [ADDR_W-1:0] m_write_address;
    logic [7:0]        m_write_data;
    logic [2:0]        m_status;
    logic              cfg_valid       = 1'b0;
    logic              cfg_ready;
    logic              cfg_index       = CFG_EXP_WIDTH;
    logic [10:0]       cfg_data        = 11'd0;

    // Decoder model state
    logic [10:0] exp_w = 11'd600;
    logic [10:0] exp_h = 11'd448;
    logic [31:0] bpos  = '0;
    logic [31:0] fsize = '0;
    logic [31:0] doff  = '0;
    logic [31:0] iw    = '0;
    logic [31:0] ih    = '0;
    logic [15:0] ibpp  = '0;
    logic [31:0] pacc  = '0;
    logic [31:0] ccol  = '0;
    logic [31:0] crow  = '0;
    logic [2:0]  ecode = ERR_NONE;
    logic [2:0]  ctab [PAL_ENTRIES];

    fb_write_t frame_writes_due [$];
    fb_write_t due;
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    int        calm_s       = 0;
    int        calm_m       = 0;

    bmp4_to_epd_palette_remap_mirror_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_file_byte     (s_file_byte),
        .s_first_byte    (s_first_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_valid   (m_write_valid),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data),
        .m_status        (m_status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [2:0] epd_code(logic [31:0] dw);
        case (dw)
            DW_RED:  return CODE_RED;
            DW_BLK:  return CODE_BLK;
            DW_GRN:  return CODE_GRN;
            DW_YEL:  return CODE_YEL;
            DW_BLU:  return CODE_BLU;
            DW_WHT:  return CODE_WHT;
            default: return CODE_CLEAR;
        endcase
    endfunction

    function automatic logic [31:0] le_merge(logic [31:0] acc, logic [31:0] p,
                                             logic [31:0] at, int unsigned n,
                                             logic [7:0] b);
        if (p >= at && p - at < n) acc |= 32'(b) << (8 * (p - at));
        return acc;
    endfunction

    // Advance the decoder model by one file byte and return the frame write it causes
    function automatic fb_write_t decode_byte(logic [7:0] b, logic f);
        fb_write_t   r;
        logic [31:0] p;
        logic [31:0] lane;
        logic [31:0] bpl;
        r = '0;
        if (f) begin
            bpos  = '0;
            fsize = '0;
            doff  = '0;
            iw    = '0;
            ih    = '0;
            ibpp  = '0;
            pacc  = '0;
            ccol  = '0;
            crow  = '0;
            ecode = ERR_NONE;
        end
        p     = bpos;
        fsize = le_merge(fsize, p, FSIZE_POS, 4, b);
        doff  = le_merge(doff, p, OFFSET_POS, 4, b);
        iw    = le_merge(iw, p, WIDTH_POS, 4, b);
        ih    = le_merge(ih, p, HEIGHT_POS, 4, b);
        ibpp  = 16'(le_merge({16'd0, ibpp}, p, BPP_POS, 2, b));

        if (p == CHECK_POS && ecode == ERR_NONE) begin
            if (ibpp != BPP_REQUIRED)
                ecode = ST_BAD_BPP;
            else if (iw != 32'(exp_w) || iw > DEC_MAX_WIDTH)
                ecode = ST_BAD_WIDTH;
            else if (ih != 32'(exp_h) || ih > DEC_MAX_HEIGHT)
                ecode = ST_BAD_HEIGHT;
            else if (doff < PAL_END)
                ecode = ST_BAD_OFFSET;
        end

        if (p >= PAL_START && p < PAL_END) begin
            lane = p - PAL_START;
            if (lane[1:0] == 2'd0) pacc = '0;
            pacc |= 32'(b) << (8 * lane[1:0]);
            if (lane[1:0] == 2'd3) ctab[lane[5:2]] = epd_code(pacc);
        end

        bpl = iw >> 1;
        if (ecode != ERR_NONE) begin
            r.status = ecode;
        end else if (p > CHECK_POS && p >= doff) begin
            if (bpl != 0 && crow < ih) begin
                // mirror within the row, swap nibbles
                r.wr   = 1'b1;
                r.addr = ADDR_W'(crow * bpl + (bpl - 1 - ccol));
                r.data = {1'b0, ctab[b[3:0]], 1'b0, ctab[b[7:4]]};
                ccol++;
                if (ccol >= bpl) begin
                    ccol = '0;
                    crow++;
                end
            end
            r.status = (bpl == 0 || crow >= ih) ? ST_DONE : ST_BUSY;
        end

        if (bpos != '1) bpos++;
        return r;
    endfunction

    // Stall length per word; now and then a calm stretch with no stalls at all
    function automatic int wait_draw(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic f, input logic ovr,
                             input logic [2:0] st, inout int sent);
        int        n;
        fb_write_t r;
        n = wait_draw(calm_s);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_file_byte  <= b;
        s_first_byte <= f;
        do @(posedge aclk); while (!s_ready);
        r = decode_byte(b, f);
        if (ovr) r.status = st;
        frame_writes_due.push_back(r);
        sent++;
    endtask

    // Hold the input until every due word is out and the pipeline has emptied
    task automatic drain();
        s_valid <= 1'b0;
        while (frame_writes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [10:0] w, input logic [10:0] h);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_EXP_WIDTH;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        exp_w = w;
        cfg_index <= CFG_EXP_HEIGHT;
        cfg_data  <= h;
        do @(posedge aclk); while (!cfg_ready);
        exp_h = h;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_file(input bmp_file_t c, inout int sent);
        logic [31:0] dw;
        logic [31:0] fsz;
        logic [7:0]  b;
        int unsigned body;
        int unsigned total;
        int unsigned k;
        dw = '0;
        // pixels start at the data offset unless it lies out of reach
        if (c.offs < PAL_END || c.offs > PAL_END + 32)
            body = PAL_END;
        else
            body = c.offs;
        total = (c.trunc != 0) ? c.trunc : body + c.npix;
        fsz   = body + c.npix;
        for (int unsigned p = 0; p < total; p++) begin
            if (p >= FSIZE_POS && p < FSIZE_POS + 4) begin
                b = 8'(fsz >> (8 * (p - FSIZE_POS)));
            end else if (p >= OFFSET_POS && p < OFFSET_POS + 4) begin
                b = 8'(c.offs >> (8 * (p - OFFSET_POS)));
            end else if (p >= WIDTH_POS && p < WIDTH_POS + 4) begin
                b = 8'(c.w >> (8 * (p - WIDTH_POS)));
            end else if (p >= HEIGHT_POS && p < HEIGHT_POS + 4) begin
                b = 8'(c.h >> (8 * (p - HEIGHT_POS)));
            end else if (p >= BPP_POS && p < BPP_POS + 2) begin
                b = 8'(c.bpp >> (8 * (p - BPP_POS)));
            end else if (p >= PAL_START && p < PAL_END) begin
                k = (p - PAL_START) % 4;
                if (k == 0) begin
                    if (c.pal == PAL_KNOWN) begin
                        dw = KNOWN_RGB[((p - PAL_START) / 4) % 7];
                    end else begin
                        case ($urandom_range(0, 4))
                            0, 1, 2: dw = KNOWN_RGB[$urandom_range(0, 6)];
                            3:       dw = KNOWN_RGB[$urandom_range(0, 6)]
                                          ^ (32'd1 << $urandom_range(0, 31));
                            default: dw = $urandom();
                        endcase
                    end
                end
                b = 8'(dw >> (8 * k));
            end else if (p >= body) begin
                case (c.fill)
                    FILL_ZERO: b = 8'h00;
                    FILL_ONES: b = 8'hff;
                    FILL_ALT:  b = (p % 2 != 0) ? 8'h0f : 8'hf0;
                    default:   b = 8'($urandom_range(0, 255));
                endcase
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            push_byte(b, c.mark && p == 0, c.chk && p == total - 1, c.st, sent);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_writes_due.size() == 0) begin
                $error("result word with no frame write due");
                mismatches++;
            end else begin
                due = frame_writes_due.pop_front();
                check_field("write_valid", 32'(due.wr), 32'(m_write_valid));
                check_field("write_address", 32'(due.addr), 32'(m_write_address));
                check_field("write_data", 32'(due.data), 32'(m_write_data));
                check_field("status", 32'(due.status), 32'(m_status));
            end
        end
    end

    // Result side: after each word, drop ready for a drawn number of cycles
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                n = wait_draw(calm_m);
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("bmp4_to_epd_palette_remap_mirror_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        bmp_file_t   c;
        int          sent;
        int          pix;
        int          nb;
        logic [10:0] gw;
        logic [10:0] gh;
        logic        noise;
        sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_PLAN[i].cw != exp_w || DIR_PLAN[i].ch != exp_h)
                set_geometry(DIR_PLAN[i].cw, DIR_PLAN[i].ch);
            send_file(DIR_PLAN[i], sent);
        end

        while (sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 9))
                    0:       gw = 11'd2;
                    1:       gw = 11'd1024;
                    2, 3:    gw = 11'($urandom_range(25, 1024));
                    default: gw = 11'($urandom_range(2, 24));
                endcase
                case ($urandom_range(0, 9))
                    0:       gh = 11'd1;
                    1:       gh = 11'd1024;
                    2:       gh = 11'($urandom_range(7, 1024));
                    default: gh = 11'($urandom_range(1, 6));
                endcase
                set_geometry(gw, gh);
            end

            c       = '0;
            c.mark  = ($urandom_range(0, 19) != 0);
            c.bpp   = BPP_REQUIRED;
            c.w     = 32'(exp_w);
            c.h     = 32'(exp_h);
            c.offs  = PAL_END + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0);
            c.pal   = ($urandom_range(0, 4) == 0) ? PAL_KNOWN : PAL_MIXED;
            c.fill  = 2'($urandom_range(0, 3));
            pix     = int'(exp_h) * int'(exp_w >> 1);
            c.npix  = 16'((pix <= 60) ? pix + $urandom_range(0, 3) : $urandom_range(1, 60));
            noise   = 1'b0;

            // mostly well-formed files; the rest broken headers, cut files and noise
            case ($urandom_range(0, 19))
                0: begin
                    c.bpp  = BPP_REQUIRED ^ 16'($urandom_range(1, 65535));
                    c.npix = 16'($urandom_range(0, 8));
                end
                1: begin
                    c.w    = c.w ^ (32'd1 << $urandom_range(0, 31));
                    c.npix = 16'($urandom_range(0, 8));
                end
                2: begin
                    c.h    = c.h ^ (32'd1 << $urandom_range(0, 31));
                    c.npix = 16'($urandom_range(0, 8));
                end
                3: begin
                    c.offs = $urandom_range(0, 117);
                    c.npix = 16'($urandom_range(0, 8));
                end
                4: c.trunc = 16'($urandom_range(1, 140));
                5: noise = 1'b1;
                default: ;
            endcase

            if (noise) begin
                nb = $urandom_range(1, 40);
                for (int k = 0; k < nb; k++)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                              1'b0, ST_BUSY, sent);
            end else begin
                send_file(c, sent);
            end
        end

        drain();
        if (mismatches == 0)
            $display("bmp4_to_epd_palette_remap_mirror_top_tb OK");
        else
            $display("bmp4_to_epd_palette_remap_mirror_top_tb NOT OK");
        $finish;
    end

endmodule

>>> bmp4_to_epd_palette_remap_mirror_top.f
hdl/bmpepd_pkg.sv
hdl/bmpepd_ram.sv
hdl/bmpepd_hdr.sv
hdl/bmpepd_pal.sv
hdl/bmpepd_pix.sv
hdl/bmp4_to_epd_palette_remap_mirror_top.sv
tb/bmp4_to_epd_palette_remap_mirror_top_tb.sv
